FILE: hdl/pwmm_pkg.sv
// ----------------------------------------------------------------------------
// pwmm_pkg
// Shared types and constants of the PWM period and duty meter.
// ----------------------------------------------------------------------------
package pwmm_pkg;

  localparam int unsigned COUNTER_BITS_DEF = 32;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_HW_PWM_MODE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMER_CLOCK_HZ = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_MS     = 2'd2;

  localparam logic [31:0] TIMER_CLOCK_HZ_RST = 32'd1000000;
  localparam logic [15:0] TIMEOUT_MS_RST     = 16'd1000;

  localparam int unsigned DUTY_W    = 14;
  localparam logic [DUTY_W-1:0] DUTY_FULL = 14'd10000;

  localparam int unsigned MS_W = 17;
  localparam logic [MS_W-1:0] MS_SAT = 17'h1FFFF;

  localparam int unsigned DIV_W  = 32;
  localparam int unsigned CNT_W  = 5;

  localparam int unsigned S_TDATA_W = 64;
  localparam int unsigned M_TDATA_W = 80;
  localparam int unsigned M_TUSER_W = 2;

  // input beat kind
  localparam logic CMD_CAPTURE = 1'b0;
  localparam logic CMD_TICK    = 1'b1;

  // capture sequence of the rise-fall-rise mode
  localparam logic [1:0] PH_RISE1 = 2'd0;
  localparam logic [1:0] PH_FALL  = 2'd1;
  localparam logic [1:0] PH_RISE2 = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_MUL,
    ST_DIV_F,
    ST_DIV_D,
    ST_OUT
  } state_e;

endpackage

FILE: hdl/pwm_period_duty_meter.sv
// ----------------------------------------------------------------------------
// pwm_period_duty_meter
// Period, frequency and duty of one PWM input from timer capture beats.
// ----------------------------------------------------------------------------
// Each input beat is a capture event or a millisecond tick; each gives one
// output beat. A tick or a capture that reports nothing goes from the
// evaluate state straight to output. A reporting capture goes on through
// the multiply state and one shared 32-bit restoring divide step, first on
// the frequency, then on the duty; the duty divide is skipped when the high
// time reaches the period and the duty saturates. The output register lets
// the next beat be accepted while a result still waits on the master side.
module pwm_period_duty_meter import pwmm_pkg::*; #(
  parameter int unsigned COUNTER_BITS = COUNTER_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // [31:0] capture_main, [63:32] capture_sub
  input  logic [S_TDATA_W-1:0]  s_axis_tdata,
  // command
  input  logic                  s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // [31:0] period_count, [63:32] frequency_hz, [77:64] duty_hundredths,
  // [78] expect_falling, [79] zero
  output logic [M_TDATA_W-1:0]  m_axis_tdata,
  // [0] measure_valid, [1] timed_out
  output logic [M_TUSER_W-1:0]  m_axis_tuser
);

  localparam int unsigned CB     = COUNTER_BITS;
  localparam int unsigned PROD_W = CB + DUTY_W;

  state_e state_q, state_d;

  logic        hw_mode_q;
  logic [31:0] clk_hz_q;
  logic [15:0] timeout_q;

  logic          cmd_q;
  logic [CB-1:0] main_q, sub_q;
  logic [1:0]    phase_q, phase_d;
  logic [CB-1:0] first_q, first_d;
  logic [CB-1:0] fall_q, fall_d;
  logic [MS_W-1:0] ms_q, ms_d;

  logic [CB-1:0] per_q, per_d;
  logic [CB-1:0] high_q, high_d;
  logic          rvalid_q, rvalid_d;
  logic          rtout_q, rtout_d;
  logic          sat_q, sat_d;
  logic [PROD_W-1:0] prod_q, prod_d;

  logic [DIV_W-1:0]  rem_q, rem_d;
  logic [DIV_W-1:0]  sr_q, sr_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [31:0]       freq_q, freq_d;
  logic [DUTY_W-1:0] duty_q, duty_d;

  logic        ovalid_q, ovalid_d;
  logic [M_TDATA_W-1:0] odata_q, odata_d;
  logic [M_TUSER_W-1:0] ouser_q, ouser_d;

  // shared divide step
  logic [DIV_W:0]   rem_sh;
  logic [DIV_W+1:0] diff;
  logic             qbit;
  logic [DIV_W-1:0] rem_nx;
  logic [DIV_W-1:0] sr_nx;

  logic            accept;
  logic            out_free;
  logic [MS_W-1:0] ms_inc;
  logic [CB-1:0]   cap_per, cap_high;
  logic            cap_rep;

  assign accept   = s_axis_tvalid && s_axis_tready;
  assign out_free = !ovalid_q || m_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE);

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = odata_q;
  assign m_axis_tuser  = ouser_q;

  assign rem_sh = {rem_q, sr_q[DIV_W-1]};
  assign diff   = {1'b0, rem_sh} - {2'b00, DIV_W'(per_q)};
  assign qbit   = !diff[DIV_W+1];
  assign rem_nx = qbit ? diff[DIV_W-1:0] : rem_sh[DIV_W-1:0];
  assign sr_nx  = {sr_q[DIV_W-2:0], qbit};

  assign ms_inc = (ms_q < MS_SAT) ? ms_q + 1'b1 : ms_q;

  // capture evaluation, rise-fall-rise sequence or hardware counts
  always_comb begin
    phase_d  = phase_q;
    first_d  = first_q;
    fall_d   = fall_q;
    cap_per  = '0;
    cap_high = '0;
    cap_rep  = 1'b0;
    if (hw_mode_q) begin
      cap_per  = main_q;
      cap_high = sub_q;
      cap_rep  = 1'b1;
    end else if (phase_q == PH_FALL) begin
      fall_d  = main_q;
      phase_d = PH_RISE2;
    end else if (phase_q == PH_RISE2) begin
      cap_per  = main_q - first_q;
      cap_high = fall_q - first_q;
      cap_rep  = 1'b1;
      phase_d  = PH_RISE1;
    end else begin
      first_d = main_q;
      phase_d = PH_FALL;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (accept) state_d = ST_EVAL;
      ST_EVAL: begin
        if ((cmd_q == CMD_CAPTURE) && cap_rep && (cap_per != '0)) state_d = ST_MUL;
        else state_d = ST_OUT;
      end
      ST_MUL:   state_d = ST_DIV_F;
      ST_DIV_F: begin
        if (cnt_q == '0) state_d = sat_q ? ST_OUT : ST_DIV_D;
      end
      ST_DIV_D: if (cnt_q == '0) state_d = ST_OUT;
      ST_OUT:   if (out_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // datapath
  always_comb begin
    ms_d     = ms_q;
    per_d    = per_q;
    high_d   = high_q;
    rvalid_d = rvalid_q;
    rtout_d  = rtout_q;
    sat_d    = sat_q;
    prod_d   = prod_q;
    rem_d    = rem_q;
    sr_d     = sr_q;
    cnt_d    = cnt_q;
    freq_d   = freq_q;
    duty_d   = duty_q;
    ovalid_d = ovalid_q && !m_axis_tready;
    odata_d  = odata_q;
    ouser_d  = ouser_q;
    unique case (state_q)
      ST_IDLE: ;
      ST_EVAL: begin
        rvalid_d = 1'b0;
        rtout_d  = 1'b0;
        if (cmd_q == CMD_TICK) begin
          ms_d = ms_inc;
          if (ms_inc > {1'b0, timeout_q}) rtout_d = 1'b1;
        end else begin
          ms_d     = '0;
          per_d    = cap_per;
          high_d   = cap_high;
          rvalid_d = cap_rep && (cap_per != '0);
        end
      end
      ST_MUL: begin
        prod_d = PROD_W'(high_q) * PROD_W'(DUTY_FULL);
        sat_d  = (high_q >= per_q);
        rem_d  = '0;
        sr_d   = clk_hz_q;
        cnt_d  = CNT_W'(DIV_W - 1);
      end
      ST_DIV_F: begin
        rem_d = rem_nx;
        sr_d  = sr_nx;
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          freq_d = sr_nx;
          duty_d = DUTY_FULL;
          rem_d  = DIV_W'(prod_q[PROD_W-1:DUTY_W]);
          sr_d   = {prod_q[DUTY_W-1:0], {(DIV_W-DUTY_W){1'b0}}};
          cnt_d  = CNT_W'(DUTY_W - 1);
        end
      end
      ST_DIV_D: begin
        rem_d = rem_nx;
        sr_d  = sr_nx;
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == '0) duty_d = sr_nx[DUTY_W-1:0];
      end
      ST_OUT: begin
        if (out_free) begin
          ovalid_d = 1'b1;
          odata_d  = {1'b0,
                      !hw_mode_q && (phase_q == PH_FALL),
                      rvalid_q ? duty_q : {DUTY_W{1'b0}},
                      rvalid_q ? freq_q : 32'd0,
                      rvalid_q ? 32'(per_q) : 32'd0};
          ouser_d  = {rtout_q, rvalid_q};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      hw_mode_q <= 1'b0;
      clk_hz_q  <= TIMER_CLOCK_HZ_RST;
      timeout_q <= TIMEOUT_MS_RST;
      phase_q   <= PH_RISE1;
      first_q   <= '0;
      fall_q    <= '0;
      ms_q      <= '0;
      ovalid_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      ms_q     <= ms_d;
      ovalid_q <= ovalid_d;
      if (state_q == ST_EVAL) begin
        if (cmd_q == CMD_TICK) begin
          if (ms_inc > {1'b0, timeout_q}) phase_q <= PH_RISE1;
        end else begin
          phase_q <= phase_d;
          first_q <= first_d;
          fall_q  <= fall_d;
        end
      end
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_HW_PWM_MODE:    hw_mode_q <= cfg_wdata_i[0];
          CFG_TIMER_CLOCK_HZ: clk_hz_q  <= cfg_wdata_i;
          CFG_TIMEOUT_MS:     timeout_q <= cfg_wdata_i[15:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q  <= s_axis_tuser;
      main_q <= s_axis_tdata[CB-1:0];
      sub_q  <= s_axis_tdata[32+CB-1:32];
    end
    per_q    <= per_d;
    high_q   <= high_d;
    rvalid_q <= rvalid_d;
    rtout_q  <= rtout_d;
    sat_q    <= sat_d;
    prod_q   <= prod_d;
    rem_q    <= rem_d;
    sr_q     <= sr_d;
    cnt_q    <= cnt_d;
    freq_q   <= freq_d;
    duty_q   <= duty_d;
    odata_q  <= odata_d;
    ouser_q  <= ouser_d;
  end

  a_duty_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[77:64] <= DUTY_FULL))
    else $error("duty above full scale");

  a_valid_period: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tdata[31:0] != 32'd0))
    else $error("measurement with zero period");

  a_tout_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser[1]) |->
      (!m_axis_tuser[0] && !m_axis_tdata[78] && (m_axis_tdata[77:0] == '0)))
    else $error("timeout beat carries data");

  a_phase_used: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q != 2'd3)
    else $error("unused capture phase entered");

  a_div_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV_D) |-> (cnt_q < CNT_W'(DUTY_W)))
    else $error("duty divide overrun");

endmodule

FILE: test/pwm_period_duty_meter_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwm_period_duty_meter_test
// Self-checking bench for the PWM period, frequency and duty meter.
// ----------------------------------------------------------------------------
// Capture and tick beats go in on the slave side with random gaps. Every
// accepted beat is run through a model of the edge sequencer, the tick
// counter and the period/frequency/duty math; its result is queued and
// compared field by field with the next output beat. The master side stalls
// at random. Directed edge cases come first, then a back-to-back tick run
// well past the timeout, then random phases under changing register settings.
// ----------------------------------------------------------------------------
module pwm_period_duty_meter_test;
  import pwmm_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;

  localparam int unsigned N_RANDOM     = 600;
  localparam int unsigned SETTLE_CYC   = 64;
  localparam int unsigned WDOG_LIMIT   = 3000;
  localparam int unsigned TICK_RUN     = 30;
  localparam int unsigned MAX_REPORTED = 10;

  typedef struct packed {
    logic              valid;
    logic [31:0]       period;
    logic [31:0]       freq;
    logic [DUTY_W-1:0] duty;
    logic              timed_out;
    logic              expect_falling;
  } meas_t;

  class pwm_meter_scoreboard;
    logic              hw_mode;
    logic [31:0]       clk_hz;
    logic [15:0]       timeout_ms;
    logic [1:0]        phase;
    logic [31:0]       rise_val;
    logic [31:0]       fall_val;
    logic [MS_W-1:0]   ms_count;
    meas_t             pending_meas[$];
    int unsigned       n_checked;
    int unsigned       n_reports;
    int unsigned       n_timeouts;
    int unsigned       n_mismatch;
    int unsigned       n_unexpected;

    function new();
      hw_mode    = 1'b0;
      clk_hz     = TIMER_CLOCK_HZ_RST;
      timeout_ms = TIMEOUT_MS_RST;
      phase      = PH_RISE1;
      rise_val   = '0;
      fall_val   = '0;
      ms_count   = '0;
      n_checked  = 0;
      n_reports  = 0;
      n_timeouts = 0;
      n_mismatch = 0;
      n_unexpected = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        CFG_HW_PWM_MODE:    hw_mode    = val[0];
        CFG_TIMER_CLOCK_HZ: clk_hz     = val;
        CFG_TIMEOUT_MS:     timeout_ms = val[15:0];
        default: ;
      endcase
    endfunction

    function meas_t form_report(logic valid, logic [31:0] per, logic [31:0] hi, logic tout);
      meas_t m;
      logic [63:0] q;
      m = '0;
      if (valid && per != 0) begin
        m.valid  = 1'b1;
        m.period = per;
        m.freq   = clk_hz / per;
        q = (64'(hi) * 64'd10000) / 64'(per);
        m.duty = (q > 64'd10000) ? DUTY_FULL : q[DUTY_W-1:0];
      end
      m.timed_out      = tout;
      m.expect_falling = !hw_mode && phase == PH_FALL;
      return m;
    endfunction

    function void note_beat(logic cmd, logic [31:0] main_v, logic [31:0] sub_v);
      meas_t m;
      if (cmd == CMD_TICK) begin
        if (ms_count != MS_SAT) ms_count++;
        if (32'(ms_count) > 32'(timeout_ms)) begin
          phase = PH_RISE1;
          m = form_report(1'b0, '0, '0, 1'b1);
          n_timeouts++;
        end else begin
          m = form_report(1'b0, '0, '0, 1'b0);
        end
      end else begin
        ms_count = '0;
        if (hw_mode) begin
          m = form_report(1'b1, main_v, sub_v, 1'b0);
        end else begin
          case (phase)
            PH_FALL: begin
              fall_val = main_v;
              phase    = PH_RISE2;
              m = form_report(1'b0, '0, '0, 1'b0);
            end
            PH_RISE2: begin
              phase = PH_RISE1;
              m = form_report(1'b1, main_v - rise_val, fall_val - rise_val, 1'b0);
            end
            default: begin
              rise_val = main_v;
              phase    = PH_FALL;
              m = form_report(1'b0, '0, '0, 1'b0);
            end
          endcase
        end
      end
      if (m.valid) n_reports++;
      pending_meas.push_back(m);
    endfunction

    function void report(string what, logic [31:0] exp_v, logic [31:0] act_v);
      n_mismatch++;
      if (n_mismatch + n_unexpected <= MAX_REPORTED)
        $display("[%0t] mismatch on %s: expected 0x%08h, got 0x%08h",
                 $realtime, what, exp_v, act_v);
    endfunction

    function void check_beat(logic [M_TDATA_W-1:0] tdata, logic [M_TUSER_W-1:0] tuser);
      meas_t e;
      if (pending_meas.size() == 0) begin
        n_unexpected++;
        if (n_mismatch + n_unexpected <= MAX_REPORTED)
          $display("[%0t] output beat with nothing expected: tdata 0x%020h tuser %b",
                   $realtime, tdata, tuser);
        return;
      end
      e = pending_meas.pop_front();
      n_checked++;
      if (tuser[0] !== e.valid) report("measure_valid", 32'(e.valid), 32'(tuser[0]));
      if (tuser[1] !== e.timed_out) report("timed_out", 32'(e.timed_out), 32'(tuser[1]));
      if (tdata[31:0] !== e.period) report("period_count", e.period, tdata[31:0]);
      if (tdata[63:32] !== e.freq) report("frequency_hz", e.freq, tdata[63:32]);
      if (tdata[77:64] !== e.duty) report("duty_hundredths", 32'(e.duty), 32'(tdata[77:64]));
      if (tdata[78] !== e.expect_falling)
        report("expect_falling", 32'(e.expect_falling), 32'(tdata[78]));
      if (tdata[79] !== 1'b0) report("tdata pad bit", 32'd0, 32'(tdata[79]));
    endfunction
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [S_TDATA_W-1:0]  s_axis_tdata;
  logic                  s_axis_tuser;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0]  m_axis_tdata;
  logic [M_TUSER_W-1:0]  m_axis_tuser;

  pwm_period_duty_meter dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  pwm_meter_scoreboard sb = new();

  bit          sender_gaps_on    = 1'b1;
  bit          receiver_stall_on = 1'b1;
  int unsigned stall_left        = 0;
  int unsigned idle_cycles       = 0;
  int unsigned n_items           = 0;
  int unsigned n_phases          = 0;

  always #4 clk_i = ~clk_i;

  function automatic int unsigned pick_idle();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(30, 120);
  endfunction

  always @(negedge clk_i) begin
    if (stall_left != 0) begin
      m_axis_tready <= 1'b0;
      stall_left--;
    end else begin
      m_axis_tready <= 1'b1;
      if (receiver_stall_on && $urandom_range(0, 99) < 30) stall_left = pick_idle();
    end
  end

  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) sb.check_beat(m_axis_tdata, m_axis_tuser);
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WDOG_LIMIT) begin
        $display("[%0t] no beat moved for %0d cycles", $realtime, WDOG_LIMIT);
        $display("pwm_period_duty_meter_test: FAIL");
        $finish;
      end
    end
  end

  task automatic send_beat(input logic cmd, input logic [31:0] main_v,
                           input logic [31:0] sub_v);
    int unsigned gap;
    gap = sender_gaps_on ? pick_idle() : 0;
    if (gap != 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tuser  = cmd;
    s_axis_tdata  = {sub_v, main_v};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_beat(cmd, main_v, sub_v);
    n_items++;
    @(negedge clk_i);
  endtask

  task automatic capture(input logic [31:0] main_v, input logic [31:0] sub_v = '0);
    send_beat(CMD_CAPTURE, main_v, sub_v);
  endtask

  task automatic tick();
    send_beat(CMD_TICK, $urandom, $urandom);
  endtask

  // wait until the block has delivered everything, then let it settle
  task automatic drain();
    s_axis_tvalid = 1'b0;
    while (sb.pending_meas.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
    repeat (SETTLE_CYC) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we_i    = 1'b1;
    cfg_idx_i   = idx;
    cfg_wdata_i = val;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    sb.write_reg(idx, val);
  endtask

  task automatic configure(input logic mode, input logic [31:0] hz, input logic [15:0] tmo);
    drain();
    write_reg(CFG_HW_PWM_MODE, 32'(mode));
    write_reg(CFG_TIMER_CLOCK_HZ, hz);
    write_reg(CFG_TIMEOUT_MS, 32'(tmo));
  endtask

  function automatic logic [31:0] pick_span();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 3) return 32'd0;
    if (r < 35) return $urandom_range(1, 16);
    if (r < 75) return $urandom_range(17, 65535);
    if (r < 80) return 32'hFFFF_FFFF;
    return $urandom;
  endfunction

  function automatic logic [31:0] pick_high(logic [31:0] per);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 10) return 32'd0;
    if (r < 20) return per;
    if (r < 70) return (per == 0) ? 32'd0 : 32'($urandom) % per;
    if (r < 85) return per + $urandom_range(1, 1000);
    return $urandom;
  endfunction

  function automatic logic [31:0] pick_hz();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 8) return 32'd0;
    if (r < 18) return 32'd1;
    if (r < 30) return 32'hFFFF_FFFF;
    if (r < 45) return TIMER_CLOCK_HZ_RST;
    return $urandom;
  endfunction

  function automatic logic [15:0] pick_timeout();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 15) return 16'd0;
    if (r < 30) return 16'd1;
    if (r < 60) return 16'($urandom_range(2, 4));
    if (r < 72) return 16'hFFFF;
    return 16'($urandom_range(5, 40));
  endfunction

  task automatic tick_burst();
    int unsigned n;
    n = $urandom_range(1, 8);
    repeat (n) tick();
  endtask

  // one rise-fall-rise sequence, picked up from wherever the sequencer stands
  task automatic edge_sequence();
    logic [31:0] base;
    logic [31:0] per;
    logic [31:0] hi;
    base = $urandom;
    per  = pick_span();
    hi   = pick_high(per);
    if (sb.phase == PH_RISE1) capture(base, $urandom);
    if ($urandom_range(0, 99) < 15) tick();
    if (sb.phase == PH_FALL) capture(base + hi, $urandom);
    if ($urandom_range(0, 99) < 15) tick();
    capture(base + per, $urandom);
  endtask

  task automatic random_phase();
    int unsigned len;
    int unsigned start;
    int unsigned r;
    logic [31:0] per;
    configure(1'($urandom_range(0, 1)), pick_hz(), pick_timeout());
    sender_gaps_on    = ($urandom_range(0, 99) < 80);
    receiver_stall_on = ($urandom_range(0, 99) < 80);
    n_phases++;
    len   = $urandom_range(30, 70);
    start = n_items;
    while (n_items - start < len) begin
      r = $urandom_range(0, 99);
      if (r < 2) begin
        drain();
      end else if (!sb.hw_mode) begin
        if (r < 72) edge_sequence();
        else if (r < 86) tick_burst();
        else capture($urandom, $urandom);
      end else begin
        if (r < 62) begin
          per = pick_span();
          capture(per, pick_high(per));
        end else if (r < 76) capture($urandom, $urandom);
        else if (r < 84) capture(32'd0, $urandom);
        else tick_burst();
      end
    end
  endtask

  initial begin
    int unsigned random_start;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = '0;
    cfg_wdata_i   = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = CMD_CAPTURE;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // reset settings: rise-fall-rise mode, 1 MHz, 1000 ms
    capture(32'd0, 32'hFFFF_FFFF);
    capture(32'd500);
    capture(32'd1000);
    capture(32'hFFFF_FF00);
    capture(32'h0000_0010);
    capture(32'h0000_0100);
    capture(32'd5);
    capture(32'd7);
    capture(32'd5);
    capture(32'd100);
    capture(32'd300);
    capture(32'd200);
    capture(32'hFFFF_FFFF);
    capture(32'hFFFF_FFFF);
    capture(32'hFFFF_FFFE);
    tick();

    configure(1'b1, 32'hFFFF_FFFF, 16'd1000);
    capture(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    capture(32'd1, 32'hFFFF_FFFF);
    capture(32'd0, 32'd5);
    capture(32'd3, 32'd1);

    // zero timeout, zero clock; sequencer state kept across mode changes
    configure(1'b0, 32'd0, 16'd0);
    capture(32'd10);
    tick();
    tick();
    capture(32'd20);
    drain();
    write_reg(CFG_HW_PWM_MODE, 32'd1);
    write_reg(CFG_UNUSED_IDX, 32'hFFFF_FFFF);
    capture(32'd50, 32'd25);
    drain();
    write_reg(CFG_HW_PWM_MODE, 32'd0);
    capture(32'd60);
    capture(32'd120);

    // tick run with no idling, crossing the timeout mid-sequence
    configure(1'b0, 32'd1, 16'd20);
    sender_gaps_on    = 1'b0;
    receiver_stall_on = 1'b0;
    capture(32'd7);
    repeat (TICK_RUN) tick();
    capture(32'd9);
    capture(32'd12);
    sender_gaps_on    = 1'b1;
    receiver_stall_on = 1'b1;

    random_start = n_items;
    while (n_items - random_start < N_RANDOM) random_phase();

    s_axis_tvalid = 1'b0;
    while (sb.pending_meas.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);

    $display("Sent %0d beats (%0d random phases); %0d results checked, %0d measurements,",
             n_items, n_phases, sb.n_checked, sb.n_reports);
    $display("%0d timeouts; %0d field mismatches, %0d unexpected beats, %0d missing.",
             sb.n_timeouts, sb.n_mismatch, sb.n_unexpected, sb.pending_meas.size());
    if (sb.n_mismatch == 0 && sb.n_unexpected == 0 && sb.pending_meas.size() == 0) begin
      $display("pwm_period_duty_meter_test: PASS");
    end else begin
      $display("pwm_period_duty_meter_test: FAIL");
    end
    $finish;
  end

endmodule

FILE: pwm_period_duty_meter.f
hdl/pwmm_pkg.sv
hdl/pwm_period_duty_meter.sv
test/pwm_period_duty_meter_test.sv
